>>> sv/pkva_pkg.sv
// Package for the key voice allocator: shared types, constants and the tone table.
`default_nettype none
package pkva_pkg;

    // Key map
    localparam int          NUM_KEYS    = 16;
    localparam int          KEY_W       = 4;
    localparam logic [3:0]  KEY_OCT_UP  = 4'd0;
    localparam logic [3:0]  KEY_OCT_DN  = 4'd1;
    localparam logic [3:0]  FIRST_NOTE  = 4'd2;
    localparam logic [3:0]  LAST_NOTE   = 4'd14;
    localparam logic [3:0]  LAST_KEY    = 4'd15;

    // Octave range
    localparam int          OCT_W       = 3;
    localparam logic [2:0]  OCT_MIN     = 3'd1;
    localparam logic [2:0]  OCT_MAX     = 3'd4;
    localparam logic [2:0]  OCT_RESET   = 3'd4;

    // Results per snapshot
    localparam int          CNT_W       = 4;
    localparam logic [3:0]  MAX_RESULTS = 4'd8;

    // Output field widths
    localparam int          HZ_W        = 10;
    localparam int          VOICE_W     = 2;

    // Tone frequency in Hz, [octave-1][key-2]
    localparam logic [9:0] TONE_TABLE [0:3][0:12] = '{
        '{10'd33,  10'd35,  10'd37,  10'd39,  10'd41,  10'd44,  10'd46,
          10'd49,  10'd52,  10'd55,  10'd58,  10'd62,  10'd65},
        '{10'd65,  10'd69,  10'd73,  10'd78,  10'd82,  10'd87,  10'd92,
          10'd98,  10'd104, 10'd110, 10'd117, 10'd123, 10'd131},
        '{10'd131, 10'd139, 10'd147, 10'd156, 10'd165, 10'd175, 10'd185,
          10'd196, 10'd208, 10'd220, 10'd233, 10'd247, 10'd262},
        '{10'd262, 10'd277, 10'd294, 10'd311, 10'd330, 10'd349, 10'd370,
          10'd392, 10'd415, 10'd440, 10'd466, 10'd494, 10'd523}
    };

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;     // take the snapshot beat
        logic step;     // compare one key
        logic flush;    // push pending event out as the final one
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic slot_free;  // a step cannot block on the pending event
        logic out_free;   // output register can take a beat
        logic pend_valid; // a pending event waits
        logic end_scan;   // this step is the last of the walk
    } t_sts;

    // Tone lookup with octave clamp; non-note keys give zero
    function automatic logic [9:0] tone_for(input logic [2:0] oct, input logic [3:0] key);
        logic [2:0] o;
        logic [1:0] row;
        logic [3:0] col;
        o = oct;
        if (o < OCT_MIN) o = OCT_MIN;
        if (o > OCT_MAX) o = OCT_MAX;
        row = 2'(o - OCT_MIN);
        col = 4'(key - FIRST_NOTE);
        if (key < FIRST_NOTE || key > LAST_NOTE) return '0;
        return TONE_TABLE[row][col];
    endfunction

endpackage
`default_nettype wire

>>> sv/pkva_ctrl.sv
// Controller for the key voice allocator: accept, key walk and final flush.
`default_nettype none
module pkva_ctrl
    import pkva_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_sts.slot_free) begin
                    o_cmd.step = 1'b1;
                    if (i_sts.end_scan) n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!i_sts.pend_valid) begin
                    n_state = ST_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> sv/pkva_datapath.sv
// Datapath for the key voice allocator: key state, voice pool, pending and output beats.
`default_nettype none
module pkva_datapath
    import pkva_pkg::*;
#(
    parameter int NUM_VOICES = 4
)(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    output t_sts                    o_sts,
    input  wire logic [NUM_KEYS-1:0] i_snap,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [VOICE_W-1:0]      o_voice,
    output logic                    o_note_on,
    output logic [KEY_W-1:0]        o_note_key,
    output logic [HZ_W-1:0]         o_tone_hz,
    output logic [OCT_W-1:0]        o_octave_now,
    output logic                    o_last_event
);

    localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int BW = $clog2(NUM_VOICES + 1);

    // Snapshot walk
    logic [NUM_KEYS-1:0]   r_snap;
    logic [KEY_W-1:0]      r_key;
    logic [CNT_W-1:0]      r_cnt;

    // Key and voice state
    logic [NUM_KEYS-1:0]   r_held;
    logic [VW-1:0]         r_kvoice [NUM_KEYS];
    logic [NUM_VOICES-1:0] r_busy;
    logic [BW-1:0]         r_busy_cnt;
    logic [OCT_W-1:0]      r_oct;

    // Pending event
    logic                  r_p_valid;
    logic [VW-1:0]         r_p_voice;
    logic                  r_p_on;
    logic [KEY_W-1:0]      r_p_key;
    logic [HZ_W-1:0]       r_p_hz;
    logic [OCT_W-1:0]      r_p_oct;

    // Output register
    logic                  r_o_valid;
    logic [VOICE_W-1:0]    r_o_voice;
    logic                  r_o_on;
    logic [KEY_W-1:0]      r_o_key;
    logic [HZ_W-1:0]       r_o_hz;
    logic [OCT_W-1:0]      r_o_oct;
    logic                  r_o_last;

    // Decode of the current key
    logic          key_down;
    logic          key_held;
    logic          is_note;
    logic          free_found;
    logic [VW-1:0] free_voice;
    logic [VW-1:0] key_vc;
    logic          press_note;
    logic          rel_note;
    logic          emit;
    logic          oct_up;
    logic          oct_dn;
    logic          rel_other;
    logic          out_free;
    logic          move_out;

    // Lowest free voice
    always_comb begin
        free_found = 1'b0;
        free_voice = '0;
        for (int v = NUM_VOICES - 1; v >= 0; v--) begin
            if (!r_busy[v]) begin
                free_found = 1'b1;
                free_voice = VW'(v);
            end
        end
    end

    // Key event decode
    always_comb begin
        key_down   = r_snap[r_key];
        key_held   = r_held[r_key];
        key_vc     = r_kvoice[r_key];
        is_note    = (r_key >= FIRST_NOTE) && (r_key <= LAST_NOTE);
        press_note = key_down && !key_held && is_note && free_found
                     && (r_busy_cnt < BW'(NUM_VOICES));
        rel_note   = !key_down && key_held && is_note;
        emit       = press_note || rel_note;
        oct_up     = key_down && !key_held && (r_key == KEY_OCT_UP) && (r_oct < OCT_MAX);
        oct_dn     = key_down && !key_held && (r_key == KEY_OCT_DN) && (r_oct > OCT_MIN);
        rel_other  = !key_down && key_held && !is_note;
    end

    // Handshake status
    assign out_free = !r_o_valid || i_out_ready;
    assign move_out = (i_cmd.step && emit && r_p_valid) || i_cmd.flush;

    always_comb begin
        o_sts.slot_free  = !r_p_valid || out_free;
        o_sts.out_free   = out_free;
        o_sts.pend_valid = r_p_valid;
        o_sts.end_scan   = (r_key == LAST_KEY)
                           || (emit && (r_cnt == MAX_RESULTS - CNT_W'(1)));
    end

    // Walk position and result count
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_snap <= i_snap;
            r_key  <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.step) begin
            r_key <= r_key + KEY_W'(1);
            if (emit) r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    // Key map, voice pool and octave
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held     <= '0;
            r_busy     <= '0;
            r_busy_cnt <= '0;
            r_oct      <= OCT_RESET;
            for (int k = 0; k < NUM_KEYS; k++) r_kvoice[k] <= '0;
        end else if (i_cmd.step) begin
            if (press_note) begin
                r_busy[free_voice] <= 1'b1;
                r_kvoice[r_key]    <= free_voice;
                r_held[r_key]      <= 1'b1;
                r_busy_cnt         <= r_busy_cnt + BW'(1);
            end else if (rel_note) begin
                if (32'(key_vc) < NUM_VOICES) r_busy[key_vc] <= 1'b0;
                if (r_busy_cnt != '0) r_busy_cnt <= r_busy_cnt - BW'(1);
                r_kvoice[r_key] <= '0;
                r_held[r_key]   <= 1'b0;
            end else if (oct_up) begin
                r_oct         <= r_oct + OCT_W'(1);
                r_held[r_key] <= 1'b1;
            end else if (oct_dn) begin
                r_oct         <= r_oct - OCT_W'(1);
                r_held[r_key] <= 1'b1;
            end else if (rel_other) begin
                r_held[r_key] <= 1'b0;
            end
        end
    end

    // Pending event valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (i_cmd.step && emit) begin
            r_p_valid <= 1'b1;
        end else if (i_cmd.flush) begin
            r_p_valid <= 1'b0;
        end
    end

    // Pending event payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.step && emit) begin
            r_p_voice <= press_note ? free_voice : key_vc;
            r_p_on    <= press_note;
            r_p_key   <= r_key;
            r_p_hz    <= press_note ? tone_for(r_oct, r_key) : '0;
            r_p_oct   <= r_oct;
        end
    end

    // Output beat valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (move_out) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    // Output beat payload; last only when the flush moves it
    always_ff @(posedge i_clk) begin
        if (move_out) begin
            r_o_voice <= VOICE_W'(r_p_voice);
            r_o_on    <= r_p_on;
            r_o_key   <= r_p_key;
            r_o_hz    <= r_p_hz;
            r_o_oct   <= r_p_oct;
            r_o_last  <= i_cmd.flush;
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_voice      = r_o_voice;
    assign o_note_on    = r_o_on;
    assign o_note_key   = r_o_key;
    assign o_tone_hz    = r_o_hz;
    assign o_octave_now = r_o_oct;
    assign o_last_event = r_o_last;

endmodule
`default_nettype wire

>>> sv/polyphonic_key_voice_allocator_top.sv
// Top level of the key voice allocator: snapshot in, note events out.
//
//  channel  | dir | payload
//  ---------+-----+--------------------------------------------------------
//  s_axis   | in  | tdata[15:0] key_snapshot
//  m_axis   | out | tdata voice, note_key, tone_hz, octave_now; tuser note_on;
//           |     | tlast last_event
//
// One snapshot runs as an accept, one step per key in the 16-key walk (the
// shared compare and voice allocation step), and a flush of the final event
// when one is pending. The walk ends early once eight events are out. The
// walk pauses while both the pending event and the output register hold
// beats. Reset is synchronous and active low and restores octave four with
// all voices free.
`default_nettype none
module polyphonic_key_voice_allocator_top
    import pkva_pkg::*;
#(
    parameter int NUM_VOICES = 4
)(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // [15:0] key_snapshot
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,  // [1:0] voice, [5:2] note_key,
                                            // [15:6] tone_hz, [18:16] octave_now
    output logic             m_axis_tuser,  // [0] note_on
    output logic             m_axis_tlast   // last_event
);

    t_cmd cmd;
    t_sts sts;

    logic [VOICE_W-1:0] voice;
    logic               note_on;
    logic [KEY_W-1:0]   note_key;
    logic [HZ_W-1:0]    tone_hz;
    logic [OCT_W-1:0]   octave_now;
    logic               last_event;

    // Sequencer
    pkva_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Key state and event datapath
    pkva_datapath #(
        .NUM_VOICES (NUM_VOICES)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_snap       (s_axis_tdata),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_voice      (voice),
        .o_note_on    (note_on),
        .o_note_key   (note_key),
        .o_tone_hz    (tone_hz),
        .o_octave_now (octave_now),
        .o_last_event (last_event)
    );

    // Beat packing
    assign m_axis_tdata = {5'b0, octave_now, tone_hz, note_key, voice};
    assign m_axis_tuser = note_on;
    assign m_axis_tlast = last_event;

endmodule
`default_nettype wire
